>>> src/mrtb_pkg.sv
// Shared constants, types and codes of the minimum-rate token bucket table.
package mrtb_pkg;

	localparam int L1_NODES   = 128;
	localparam int QUEUES     = 1024;
	localparam int REFRESH_NS = 80;

	localparam int L1_AW    = $clog2(L1_NODES);
	localparam int Q_AW     = $clog2(QUEUES);
	localparam int PHASE_W  = $clog2(REFRESH_NS);
	localparam int PERIOD_W = 16;

	// Operand and sum widths of the shared saturating adder.
	localparam int OPND_W = 34;
	localparam int SUM_W  = 35;

	typedef enum logic [2:0] {
		KIND_TICK     = 3'd0,
		KIND_UPDATE   = 3'd1,
		KIND_WRITE_L1 = 3'd2,
		KIND_WRITE_Q  = 3'd3,
		KIND_QUERY    = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_UPD_L1,
		ST_UPD_Q,
		ST_REF_RD,
		ST_REF_ACC,
		ST_REF_BKT,
		ST_RES_RD,
		ST_RES_OUT
	} state_t;

	typedef struct packed {
		logic [11:0] fill_mant;
		logic [2:0]  fill_exp;
		logic        pps;
		logic [11:0] burst_mant;
		logic [3:0]  burst_exp;
		logic        enable;
	} rate_entry_t;

endpackage

>>> src/min_rate_token_bucket_table.sv
// Top level of the minimum-rate token bucket table for L1 nodes and queues.
// After reset the block sweeps all tables to zero, one entry a cycle, over all 1024
// queue addresses before it takes its first request. A byte update, entry write,
// query or plain tick then goes through ST_DISPATCH (a byte update also through
// ST_UPD_L1 and ST_UPD_Q), ST_RES_RD and ST_RES_OUT; the tick that ends an 80 ns
// period walks all 128 L1 entries and 1024 queues through one shared saturating adder
// in ST_REF_RD, ST_REF_ACC and ST_REF_BKT per entry, paced by the single read ports
// and that adder. The next request is taken while a result still waits at the output.
module min_rate_token_bucket_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic [6:0]         l1_index,
	input  logic [9:0]         queue_index,
	input  logic [13:0]        byte_count,
	input  logic               end_of_packet,
	input  logic [2:0]         charge_mask,
	input  logic [11:0]        rate_mantissa,
	input  logic [2:0]         rate_exponent,
	input  logic               per_packet_mode,
	input  logic [11:0]        burst_mantissa,
	input  logic [3:0]         burst_exponent,
	input  logic               min_rate_enable,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               l1_positive,
	output logic               queue_positive,
	output logic signed [31:0] l1_level,
	output logic signed [31:0] queue_level,
	output logic               refreshed
);

	localparam int L1_AW = mrtb_pkg::L1_AW;
	localparam int Q_AW  = mrtb_pkg::Q_AW;
	localparam int OW    = mrtb_pkg::OPND_W;

	mrtb_pkg::state_t state_q, state_d;

	logic [Q_AW-1:0]              walk_q, walk_d;
	logic                         lvl_q, lvl_d;
	logic [mrtb_pkg::PHASE_W-1:0] phase_q;
	logic [mrtb_pkg::PERIOD_W-1:0] period_q;
	logic signed [7:0]            adj_q;
	logic signed [31:0]           tmp_q;
	logic                         refreshed_q;
	logic                         out_valid_q;

	// Captured request.
	logic [2:0]             kind_q;
	logic [L1_AW-1:0]       li_q;
	logic [Q_AW-1:0]        qi_q;
	logic                   l1_ok_q, q_ok_q;
	logic [13:0]            bytes_q;
	logic                   eop_q;
	logic [2:0]             mask_q;
	mrtb_pkg::rate_entry_t  wr_entry_q;

	// Tables.
	logic signed [31:0]    l1_acc_mem  [mrtb_pkg::L1_NODES];
	logic signed [31:0]    l1_bkt_mem  [mrtb_pkg::L1_NODES];
	mrtb_pkg::rate_entry_t l1_rate_mem [mrtb_pkg::L1_NODES];
	logic signed [31:0]    q_acc_mem   [mrtb_pkg::QUEUES];
	logic signed [31:0]    q_bkt_mem   [mrtb_pkg::QUEUES];
	mrtb_pkg::rate_entry_t q_rate_mem  [mrtb_pkg::QUEUES];

	logic signed [31:0]    l1_acc_rd, l1_bkt_rd, q_acc_rd, q_bkt_rd;
	mrtb_pkg::rate_entry_t l1_rate_rd, q_rate_rd;

	logic [L1_AW-1:0]      l1_addr;
	logic [Q_AW-1:0]       q_addr;
	logic                  l1_acc_we, l1_bkt_we, l1_rate_we;
	logic                  q_acc_we, q_bkt_we, q_rate_we;
	logic signed [31:0]    l1_acc_wd, l1_bkt_wd, q_acc_wd, q_bkt_wd;
	mrtb_pkg::rate_entry_t rate_wd;

	logic signed [OW-1:0]              alu_a, alu_b;
	logic signed [mrtb_pkg::SUM_W-1:0] alu_sum;
	logic signed [31:0]                alu_sat;

	logic                  walk_mode;
	logic                  accept;
	logic                  out_load;
	logic                  tick_wrap;
	logic signed [16:0]    chg;
	logic signed [31:0]    sel_acc, sel_bkt;
	mrtb_pkg::rate_entry_t sel_ent;
	logic [3:0]            ref_exp;
	logic [25:0]           refresh_bytes;
	logic                  refresh_gate;
	logic [26:0]           burst_cap;
	logic signed [31:0]    bkt_new;
	logic                  walk_last;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == mrtb_pkg::ST_IDLE);
	assign tick_wrap = (phase_q == mrtb_pkg::PHASE_W'(mrtb_pkg::REFRESH_NS - 1));
	assign walk_mode = (state_q == mrtb_pkg::ST_CLEAR) || (state_q == mrtb_pkg::ST_REF_RD) ||
		(state_q == mrtb_pkg::ST_REF_ACC) || (state_q == mrtb_pkg::ST_REF_BKT);
	assign l1_addr   = walk_mode ? walk_q[L1_AW-1:0] : li_q;
	assign q_addr    = walk_mode ? walk_q : qi_q;
	assign walk_last = lvl_q ? (walk_q == Q_AW'(mrtb_pkg::QUEUES - 1))
		: (walk_q == Q_AW'(mrtb_pkg::L1_NODES - 1));

	always_ff @(posedge clk) begin
		if (l1_acc_we) l1_acc_mem[l1_addr] <= l1_acc_wd;
		l1_acc_rd <= l1_acc_mem[l1_addr];
	end
	always_ff @(posedge clk) begin
		if (l1_bkt_we) l1_bkt_mem[l1_addr] <= l1_bkt_wd;
		l1_bkt_rd <= l1_bkt_mem[l1_addr];
	end
	always_ff @(posedge clk) begin
		if (l1_rate_we) l1_rate_mem[l1_addr] <= rate_wd;
		l1_rate_rd <= l1_rate_mem[l1_addr];
	end
	always_ff @(posedge clk) begin
		if (q_acc_we) q_acc_mem[q_addr] <= q_acc_wd;
		q_acc_rd <= q_acc_mem[q_addr];
	end
	always_ff @(posedge clk) begin
		if (q_bkt_we) q_bkt_mem[q_addr] <= q_bkt_wd;
		q_bkt_rd <= q_bkt_mem[q_addr];
	end
	always_ff @(posedge clk) begin
		if (q_rate_we) q_rate_mem[q_addr] <= rate_wd;
		q_rate_rd <= q_rate_mem[q_addr];
	end

	mrtb_sat_add u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum),
		.sat (alu_sat)
	);

	// Operands for the refresh walk come from whichever level is being walked.
	always_comb begin
		sel_acc       = lvl_q ? q_acc_rd : l1_acc_rd;
		sel_bkt       = lvl_q ? q_bkt_rd : l1_bkt_rd;
		sel_ent       = lvl_q ? q_rate_rd : l1_rate_rd;
		ref_exp       = sel_ent.pps ? {sel_ent.fill_exp, 1'b0} : {1'b0, sel_ent.fill_exp};
		refresh_bytes = 26'(sel_ent.fill_mant) << ref_exp;
		refresh_gate  = ((period_q & ((mrtb_pkg::PERIOD_W'(1) << ref_exp)
			- mrtb_pkg::PERIOD_W'(1))) == '0);
		burst_cap     = 27'(sel_ent.burst_mant) << sel_ent.burst_exp;
		chg           = $signed({3'b000, bytes_q}) + (eop_q ? 17'(adj_q) : 17'sd0);
		bkt_new       = (alu_sum > $signed({8'b0, burst_cap}))
			? $signed({5'b0, burst_cap}) : alu_sat;
	end

	always_comb begin
		state_d    = state_q;
		walk_d     = walk_q;
		lvl_d      = lvl_q;
		out_load   = 1'b0;
		alu_a      = OW'(sel_bkt);
		alu_b      = OW'(tmp_q);
		l1_acc_we  = 1'b0;
		l1_bkt_we  = 1'b0;
		l1_rate_we = 1'b0;
		q_acc_we   = 1'b0;
		q_bkt_we   = 1'b0;
		q_rate_we  = 1'b0;
		l1_acc_wd  = alu_sat;
		q_acc_wd   = alu_sat;
		l1_bkt_wd  = bkt_new;
		q_bkt_wd   = bkt_new;
		rate_wd    = wr_entry_q;
		unique case (state_q)
			mrtb_pkg::ST_CLEAR: begin
				l1_acc_wd  = '0;
				q_acc_wd   = '0;
				l1_bkt_wd  = '0;
				q_bkt_wd   = '0;
				rate_wd    = '0;
				l1_acc_we  = (int'(walk_q) < mrtb_pkg::L1_NODES);
				l1_bkt_we  = l1_acc_we;
				l1_rate_we = l1_acc_we;
				q_acc_we   = 1'b1;
				q_bkt_we   = 1'b1;
				q_rate_we  = 1'b1;
				walk_d     = walk_q + Q_AW'(1);
				if (walk_q == Q_AW'(mrtb_pkg::QUEUES - 1)) begin
					walk_d  = '0;
					state_d = mrtb_pkg::ST_IDLE;
				end
			end
			mrtb_pkg::ST_IDLE: begin
				if (accept) state_d = mrtb_pkg::ST_DISPATCH;
			end
			mrtb_pkg::ST_DISPATCH: begin
				state_d = mrtb_pkg::ST_RES_RD;
				unique case (kind_q)
					mrtb_pkg::KIND_TICK: begin
						if (tick_wrap) begin
							walk_d  = '0;
							lvl_d   = 1'b0;
							state_d = mrtb_pkg::ST_REF_RD;
						end
					end
					mrtb_pkg::KIND_UPDATE:   state_d = mrtb_pkg::ST_UPD_L1;
					mrtb_pkg::KIND_WRITE_L1: l1_rate_we = l1_ok_q;
					mrtb_pkg::KIND_WRITE_Q:  q_rate_we = q_ok_q;
					default: ;
				endcase
			end
			mrtb_pkg::ST_UPD_L1: begin
				alu_a     = OW'(l1_acc_rd);
				alu_b     = -OW'(chg);
				l1_acc_we = mask_q[2] && l1_ok_q;
				state_d   = mrtb_pkg::ST_UPD_Q;
			end
			mrtb_pkg::ST_UPD_Q: begin
				alu_a    = OW'(q_acc_rd);
				alu_b    = -OW'(chg);
				q_acc_we = mask_q[0] && q_ok_q;
				state_d  = mrtb_pkg::ST_RES_RD;
			end
			mrtb_pkg::ST_REF_RD: state_d = mrtb_pkg::ST_REF_ACC;
			mrtb_pkg::ST_REF_ACC: begin
				alu_a   = OW'(sel_acc);
				alu_b   = refresh_gate ? $signed({8'b0, refresh_bytes}) : '0;
				state_d = mrtb_pkg::ST_REF_BKT;
			end
			mrtb_pkg::ST_REF_BKT: begin
				l1_acc_wd = '0;
				q_acc_wd  = '0;
				l1_acc_we = !lvl_q;
				l1_bkt_we = !lvl_q;
				q_acc_we  = lvl_q;
				q_bkt_we  = lvl_q;
				walk_d    = walk_q + Q_AW'(1);
				state_d   = mrtb_pkg::ST_REF_RD;
				if (walk_last) begin
					walk_d = '0;
					if (lvl_q) begin
						state_d = mrtb_pkg::ST_RES_RD;
					end else begin
						lvl_d = 1'b1;
					end
				end
			end
			mrtb_pkg::ST_RES_RD: state_d = mrtb_pkg::ST_RES_OUT;
			mrtb_pkg::ST_RES_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = mrtb_pkg::ST_IDLE;
				end
			end
			default: state_d = mrtb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrtb_pkg::ST_CLEAR;
			walk_q      <= '0;
			lvl_q       <= 1'b0;
			phase_q     <= '0;
			period_q    <= '0;
			adj_q       <= '0;
			refreshed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			walk_q  <= walk_d;
			lvl_q   <= lvl_d;
			if (cfg_we) adj_q <= $signed(cfg_wdata);
			if (state_q == mrtb_pkg::ST_DISPATCH) begin
				refreshed_q <= (kind_q == mrtb_pkg::KIND_TICK) && tick_wrap;
				if (kind_q == mrtb_pkg::KIND_TICK) begin
					if (tick_wrap) begin
						phase_q  <= '0;
						period_q <= period_q + mrtb_pkg::PERIOD_W'(1);
					end else begin
						phase_q <= phase_q + mrtb_pkg::PHASE_W'(1);
					end
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= kind;
			li_q       <= L1_AW'(l1_index);
			qi_q       <= Q_AW'(queue_index);
			l1_ok_q    <= (int'(l1_index) < mrtb_pkg::L1_NODES);
			q_ok_q     <= (int'(queue_index) < mrtb_pkg::QUEUES);
			bytes_q    <= byte_count;
			eop_q      <= end_of_packet;
			mask_q     <= charge_mask;
			wr_entry_q <= '{fill_mant: rate_mantissa, fill_exp: rate_exponent,
				pps: per_packet_mode, burst_mant: burst_mantissa,
				burst_exp: burst_exponent, enable: min_rate_enable};
		end
		if (state_q == mrtb_pkg::ST_REF_ACC) tmp_q <= alu_sat;
		if (out_load) begin
			l1_positive    <= l1_ok_q && l1_rate_rd.enable && !l1_bkt_rd[31];
			queue_positive <= q_ok_q && q_rate_rd.enable && !q_bkt_rd[31];
			l1_level       <= l1_ok_q ? l1_bkt_rd : 32'sd0;
			queue_level    <= q_ok_q ? q_bkt_rd : 32'sd0;
			refreshed      <= refreshed_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrtb_pkg::ST_CLEAR) |-> !in_ready)
		else $error("request accepted during table clear");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second request accepted while one is in progress");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(phase_q) < mrtb_pkg::REFRESH_NS)
		else $error("nanosecond phase out of range");
	a_bucket_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrtb_pkg::ST_REF_BKT) |-> (bkt_new <= $signed({5'b0, burst_cap})))
		else $error("refreshed bucket exceeds its size");
`endif

endmodule

>>> src/mrtb_sat_add.sv
// Shared adder that saturates its result to the signed 32-bit range.
module mrtb_sat_add (
	input  logic signed [mrtb_pkg::OPND_W-1:0] a,
	input  logic signed [mrtb_pkg::OPND_W-1:0] b,
	output logic signed [mrtb_pkg::SUM_W-1:0]  sum,
	output logic signed [31:0]                 sat
);

	localparam logic signed [mrtb_pkg::SUM_W-1:0] MaxVal =
		mrtb_pkg::SUM_W'(signed'(32'sh7fffffff));
	localparam logic signed [mrtb_pkg::SUM_W-1:0] MinVal =
		mrtb_pkg::SUM_W'(signed'(32'sh80000000));

	assign sum = mrtb_pkg::SUM_W'(a) + mrtb_pkg::SUM_W'(b);

	always_comb begin
		if (sum > MaxVal) begin
			sat = 32'sh7fffffff;
		end else if (sum < MinVal) begin
			sat = 32'sh80000000;
		end else begin
			sat = sum[31:0];
		end
	end

endmodule
